// ===== design/circ_nh_pkg.sv =====
// Shared types, constants and register codes for the circulant next-hop router.
// Used by circulant_next_hop; depends on nothing else.
package circ_nh_pkg;

   localparam int NODE_BITS      = 16;
   localparam int GEN_SLOTS      = 4;
   localparam int MAX_GENS       = 4;
   localparam int GEN_LIMIT      = (MAX_GENS < GEN_SLOTS) ? MAX_GENS : GEN_SLOTS;
   localparam int CNT_BITS       = 3;
   localparam int CSR_INDEX_BITS = 3;

   localparam int LANE_CUR   = 0;
   localparam int LANE_DST   = 1;
   localparam int LANE_GEN0  = 2;
   localparam int MOD_LANES  = LANE_GEN0 + GEN_SLOTS;
   localparam int MOD_STEPS  = NODE_BITS;

   localparam int STAGE_DIST = MOD_STEPS + 1;
   localparam int STAGE_FOLD = MOD_STEPS + 2;
   localparam int STAGE_SEL  = MOD_STEPS + 3;
   localparam int STAGE_OUT  = MOD_STEPS + 4;
   localparam int STAGE_W    = STAGE_OUT + 1;

   typedef logic [NODE_BITS-1:0] node_type;
   typedef logic [NODE_BITS:0]   wide_type;
   typedef logic [CNT_BITS-1:0]  count_type;

   localparam count_type GEN_LIMIT_C = count_type'(GEN_LIMIT);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CFG_RING_SIZE  = 3'd0,
      CFG_GEN_COUNT  = 3'd1,
      CFG_ROUTE_MODE = 3'd2,
      CFG_JUMP_A     = 3'd3,
      CFG_JUMP_B     = 3'd4,
      CFG_JUMP_C     = 3'd5,
      CFG_JUMP_D     = 3'd6
   } cfg_index_type;

   typedef enum logic {
      ROUTE_GREEDY   = 1'b0,
      ROUTE_MIDPOINT = 1'b1
   } route_mode_type;

   localparam node_type       RST_RING_SIZE  = node_type'(16);
   localparam count_type      RST_GEN_COUNT  = count_type'(2);
   localparam route_mode_type RST_ROUTE_MODE = ROUTE_GREEDY;
   localparam node_type       RST_JUMP_A     = node_type'(1);
   localparam node_type       RST_JUMP_B     = node_type'(2);
   localparam node_type       RST_JUMP_C     = node_type'(3);
   localparam node_type       RST_JUMP_D     = node_type'(4);

   typedef struct packed {
      node_type [MOD_LANES-1:0] num;
      node_type [MOD_LANES-1:0] rem;
   } mod_stage_type;

   typedef struct packed {
      node_type                 cur;
      node_type                 span;
      node_type [GEN_SLOTS-1:0] gen_mod;
   } dist_stage_type;

   typedef struct packed {
      node_type                 cur;
      node_type                 span;
      logic                     back;
      node_type [GEN_SLOTS-1:0] gen_mod;
   } fold_stage_type;

   typedef struct packed {
      node_type cur;
      node_type step;
      logic     back;
      logic     found;
   } sel_stage_type;

   typedef struct packed {
      node_type next_node;
      logic     no_route;
   } rsp_stage_type;

endpackage

// ===== design/circulant_next_hop.sv =====
// A transaction passes the remainder, dist, fold, sel and output stages to rsp_valid.
// Throughput: one transaction per cycle; the pipeline is set by the 16-stage
// remainder pipeline that reduces the nodes and jumps by the ring size.
// Empty stages collapse; a stalled result blocks input only once every stage is full.
// Synchronous reset empties the pipeline and loads the register defaults.
module circulant_next_hop (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  circ_nh_pkg::node_type                    req_current_node,
   input  circ_nh_pkg::node_type                    req_dest_node,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output circ_nh_pkg::node_type                    rsp_next_node,
   output logic                                     rsp_no_route,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [circ_nh_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  circ_nh_pkg::node_type                    csr_data
);
   import circ_nh_pkg::*;

   node_type       ring_size_ff, ring_size_in;
   count_type      gen_count_ff, gen_count_in;
   route_mode_type route_mode_ff, route_mode_in;
   node_type       jump_ff [GEN_SLOTS];
   node_type       jump_in [GEN_SLOTS];

   node_type       ring_n;
   node_type       half_n;
   count_type      gen_avail;

   logic [STAGE_W-1:0] vld_ff, vld_in, move;

   mod_stage_type  mod_ff [MOD_STEPS+1];
   mod_stage_type  mod_in [MOD_STEPS+1];
   dist_stage_type dist_ff, dist_in;
   fold_stage_type fold_ff, fold_in;
   sel_stage_type  sel_ff, sel_in;
   rsp_stage_type  rsp_ff, rsp_in;

   logic [GEN_SLOTS-1:0] fit;
   logic [GEN_SLOTS-1:0] pair;

   assign csr_ready = 1'b1;

   always_comb begin
      ring_size_in  = ring_size_ff;
      gen_count_in  = gen_count_ff;
      route_mode_in = route_mode_ff;
      jump_in       = jump_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CFG_RING_SIZE:  ring_size_in  = csr_data;
            CFG_GEN_COUNT:  gen_count_in  = csr_data[CNT_BITS-1:0];
            CFG_ROUTE_MODE: route_mode_in = route_mode_type'(csr_data[0]);
            CFG_JUMP_A:     jump_in[0]    = csr_data;
            CFG_JUMP_B:     jump_in[1]    = csr_data;
            CFG_JUMP_C:     jump_in[2]    = csr_data;
            CFG_JUMP_D:     jump_in[3]    = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff  <= RST_RING_SIZE;
         gen_count_ff  <= RST_GEN_COUNT;
         route_mode_ff <= RST_ROUTE_MODE;
         jump_ff[0]    <= RST_JUMP_A;
         jump_ff[1]    <= RST_JUMP_B;
         jump_ff[2]    <= RST_JUMP_C;
         jump_ff[3]    <= RST_JUMP_D;
      end else begin
         ring_size_ff  <= ring_size_in;
         gen_count_ff  <= gen_count_in;
         route_mode_ff <= route_mode_in;
         jump_ff       <= jump_in;
      end
   end

   // A ring size of zero behaves as a single-node ring.
   assign ring_n    = (ring_size_ff == '0) ? node_type'(1) : ring_size_ff;
   assign half_n    = ring_n >> 1;
   assign gen_avail = (gen_count_ff > GEN_LIMIT_C) ? GEN_LIMIT_C : gen_count_ff;

   // A stage may load when some stage at or after it is empty or the output drains.
   always_comb begin
      for (int i = 0; i < STAGE_W; i++) begin
         move[i] = !rsp_stall ||
                   ((vld_ff | ((STAGE_W'(1) << i) - STAGE_W'(1))) != '1);
      end
      vld_in[0] = move[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < STAGE_W; i++) begin
         vld_in[i] = move[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   assign req_stall = !move[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Restoring remainder pipeline, one bit of every lane per stage.
   always_comb begin
      wide_type trial;
      mod_in[0].num[LANE_CUR] = req_current_node;
      mod_in[0].num[LANE_DST] = req_dest_node;
      for (int g = 0; g < GEN_SLOTS; g++) begin
         mod_in[0].num[LANE_GEN0+g] = jump_ff[g];
      end
      mod_in[0].rem = '0;
      for (int s = 0; s < MOD_STEPS; s++) begin
         for (int l = 0; l < MOD_LANES; l++) begin
            trial = {mod_ff[s].rem[l], mod_ff[s].num[l][NODE_BITS-1]};
            if (trial >= {1'b0, ring_n}) begin
               trial = trial - {1'b0, ring_n};
            end
            mod_in[s+1].rem[l] = trial[NODE_BITS-1:0];
            mod_in[s+1].num[l] = mod_ff[s].num[l] << 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= MOD_STEPS; s++) begin
         if (move[s]) begin
            mod_ff[s] <= mod_in[s];
         end
      end
   end

   always_comb begin
      node_type cur;
      node_type dst;
      cur = mod_ff[MOD_STEPS].rem[LANE_CUR];
      dst = mod_ff[MOD_STEPS].rem[LANE_DST];
      dist_in.cur = cur;
      if (dst >= cur) begin
         dist_in.span = dst - cur;
      end else begin
         dist_in.span = node_type'({1'b0, dst} + {1'b0, ring_n} - {1'b0, cur});
      end
      for (int g = 0; g < GEN_SLOTS; g++) begin
         dist_in.gen_mod[g] = mod_ff[MOD_STEPS].rem[LANE_GEN0+g];
      end
   end

   always_comb begin
      fold_in.cur     = dist_ff.cur;
      fold_in.gen_mod = dist_ff.gen_mod;
      fold_in.back    = dist_ff.span > half_n;
      fold_in.span    = fold_in.back ? (ring_n - dist_ff.span) : dist_ff.span;
   end

   always_comb begin
      for (int g = 0; g < GEN_SLOTS; g++) begin
         fit[g]  = (count_type'(g) < gen_avail) && (fold_ff.span >= jump_ff[g]);
         pair[g] = 1'b0;
         if (g > 0) begin
            pair[g] = (count_type'(g) < gen_avail) &&
                      ({fold_ff.span, 1'b0} > ({1'b0, jump_ff[g-1]} + {1'b0, jump_ff[g]}));
         end
      end
      sel_in.cur   = fold_ff.cur;
      sel_in.back  = fold_ff.back;
      sel_in.step  = '0;
      sel_in.found = 1'b0;
      if (route_mode_ff == ROUTE_GREEDY) begin
         if (fold_ff.span == '0) begin
            sel_in.found = 1'b1;
         end else begin
            for (int g = 0; g < GEN_SLOTS; g++) begin
               if (fit[g]) begin
                  sel_in.found = 1'b1;
                  sel_in.step  = fold_ff.gen_mod[g];
               end
            end
         end
      end else if (gen_avail != '0) begin
         sel_in.found = 1'b1;
         sel_in.step  = fold_ff.gen_mod[0];
         for (int g = 1; g < GEN_SLOTS; g++) begin
            if (pair[g]) begin
               sel_in.step = fold_ff.gen_mod[g];
            end
         end
      end
   end

   always_comb begin
      wide_type fwd;
      node_type bwd;
      fwd = {1'b0, sel_ff.cur} + {1'b0, sel_ff.step};
      if (fwd >= {1'b0, ring_n}) begin
         fwd = fwd - {1'b0, ring_n};
      end
      if (sel_ff.cur >= sel_ff.step) begin
         bwd = sel_ff.cur - sel_ff.step;
      end else begin
         bwd = node_type'({1'b0, sel_ff.cur} + {1'b0, ring_n} - {1'b0, sel_ff.step});
      end
      if (!sel_ff.found) begin
         rsp_in.next_node = '0;
         rsp_in.no_route  = 1'b1;
      end else begin
         rsp_in.next_node = sel_ff.back ? bwd : fwd[NODE_BITS-1:0];
         rsp_in.no_route  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move[STAGE_DIST]) begin
         dist_ff <= dist_in;
      end
      if (move[STAGE_FOLD]) begin
         fold_ff <= fold_in;
      end
      if (move[STAGE_SEL]) begin
         sel_ff <= sel_in;
      end
      if (move[STAGE_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid     = vld_ff[STAGE_OUT];
   assign rsp_next_node = rsp_ff.next_node;
   assign rsp_no_route  = rsp_ff.no_route;

   a_no_route_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_route |-> rsp_next_node == '0)
      else $error("No-route result carries a nonzero node.");

   a_next_in_ring: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_next_node < ring_n)
      else $error("Next node lies outside the ring.");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&vld_ff))
      else $error("Input stalled while the pipeline has an empty stage.");

   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[0])
      else $error("Accepted transaction did not enter the pipeline.");

   a_midpoint_routes: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STAGE_SEL] && (route_mode_ff == ROUTE_MIDPOINT) && (gen_avail != '0)
      |-> sel_ff.found)
      else $error("Midpoint rule failed to pick a jump.");

endmodule
